### src/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg: shared definitions for the fixed-partition fit allocator
// Field widths, request and status codes, fit policy codes and the
// control bundle between the sequencer and the partition table.
// ----------------------------------------------------------------------------
`default_nettype none

package fpfa_pkg;

  // default sizing
  localparam int unsigned MAX_PARTITIONS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF      = 16;

  // fixed channel field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned PSIZE_W  = 16;
  localparam int unsigned POLICY_W = 2;

  // request actions
  localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // fit policies (the unused code behaves as first fit)
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // table update commands from the sequencer
  typedef struct packed {
    logic append;       // write size at end of table, clear its mark, bump count
    logic mark;         // set allocated mark of the picked entry
    logic release_all;  // clear every allocated mark
  } tbl_ctl_t;

endpackage

`default_nettype wire

### src/fpfa_req_if.sv
// ----------------------------------------------------------------------------
// fpfa_req_if: request channel
// Valid/ready channel carrying one allocator request.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [fpfa_pkg::ACTION_W-1:0] action;
  logic [fpfa_pkg::AMOUNT_W-1:0] amount;

  modport source (output valid, output action, output amount, input ready);
  modport sink   (input valid, input action, input amount, output ready);
endinterface

`default_nettype wire

### src/fpfa_rsp_if.sv
// ----------------------------------------------------------------------------
// fpfa_rsp_if: result channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fpfa_pkg::STATUS_W-1:0] status;
  logic [fpfa_pkg::INDEX_W-1:0]  partition_index;
  logic [fpfa_pkg::PSIZE_W-1:0]  partition_size;

  modport source (output valid, output status, output partition_index,
                  output partition_size, input ready);
  modport sink   (input valid, input status, input partition_index,
                  input partition_size, output ready);
endinterface

`default_nettype wire

### src/fpfa_table.sv
// ----------------------------------------------------------------------------
// fpfa_table: partition table storage
// Size memory with registered read, allocated mark flops and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_table #(
  parameter int unsigned MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
  parameter int unsigned SIZE_BITS      = fpfa_pkg::SIZE_BITS_DEF,
  localparam int unsigned IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_PARTITIONS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fpfa_pkg::tbl_ctl_t    ctl,
  input  wire logic [SIZE_BITS-1:0]  wr_size,
  input  wire logic [IDX_W-1:0]      mark_idx,
  input  wire logic [IDX_W-1:0]      rd_idx,
  output logic      [SIZE_BITS-1:0]  rd_size,
  output logic                       rd_used,
  output logic      [CNT_W-1:0]      count
);

  logic [SIZE_BITS-1:0]      size_mem [MAX_PARTITIONS];
  logic [SIZE_BITS-1:0]      rd_size_r;
  logic                      rd_used_r;
  logic [MAX_PARTITIONS-1:0] used_r;
  logic [CNT_W-1:0]          count_r;
  logic [IDX_W-1:0]          wr_idx;

  assign wr_idx = count_r[IDX_W-1:0];

  // size memory: one write port at the table end, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.append) begin
      size_mem[wr_idx] <= wr_size;
    end
    rd_size_r <= size_mem[rd_idx];
    rd_used_r <= used_r[rd_idx];
  end

  // allocated marks and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      count_r <= '0;
    end else begin
      if (ctl.release_all) begin
        used_r <= '0;
      end else if (ctl.append) begin
        used_r[wr_idx] <= 1'b0;
      end else if (ctl.mark) begin
        used_r[mark_idx] <= 1'b1;
      end
      if (ctl.append) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  assign rd_size = rd_size_r;
  assign rd_used = rd_used_r;
  assign count   = count_r;

endmodule

`default_nettype wire

### src/fpfa_seq.sv
// ----------------------------------------------------------------------------
// fpfa_seq: request sequencer and fit compare unit
// Decodes requests, steps one table entry per cycle through a shared
// compare unit for allocation, and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_seq #(
  parameter int unsigned MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
  parameter int unsigned SIZE_BITS      = fpfa_pkg::SIZE_BITS_DEF,
  localparam int unsigned IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_PARTITIONS + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  fpfa_req_if.sink                             in_req,
  input  wire logic [fpfa_pkg::POLICY_W-1:0]   fit_policy,
  output fpfa_pkg::tbl_ctl_t                   tbl_ctl,
  output logic      [SIZE_BITS-1:0]            wr_size,
  output logic      [IDX_W-1:0]                mark_idx,
  output logic      [IDX_W-1:0]                rd_idx,
  input  wire logic [SIZE_BITS-1:0]            rd_size,
  input  wire logic                            rd_used,
  input  wire logic [CNT_W-1:0]                count,
  output logic                                 res_vld,
  input  wire logic                            res_rdy,
  output logic      [fpfa_pkg::STATUS_W-1:0]   res_status,
  output logic      [fpfa_pkg::INDEX_W-1:0]    res_index,
  output logic      [fpfa_pkg::PSIZE_W-1:0]    res_size
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0]                    state_r, state_nxt;
  logic [SIZE_BITS-1:0]          amt_r, amt_nxt;
  logic [CNT_W-1:0]              scan_r, scan_nxt;
  logic                          cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]              cmp_idx_r, cmp_idx_nxt;
  logic                          found_r, found_nxt;
  logic [IDX_W-1:0]              pick_r, pick_nxt;
  logic [SIZE_BITS-1:0]          pick_size_r, pick_size_nxt;
  logic [fpfa_pkg::STATUS_W-1:0] stat_r, stat_nxt;
  logic [fpfa_pkg::INDEX_W-1:0]  ridx_r, ridx_nxt;
  logic [fpfa_pkg::PSIZE_W-1:0]  rsize_r, rsize_nxt;

  logic                          acc;
  logic [SIZE_BITS+15:0]         amt_ext;
  logic [SIZE_BITS-1:0]          amt_in;
  logic [SIZE_BITS+15:0]         app_size_ext;
  logic [SIZE_BITS+15:0]         pick_size_ext;
  logic [CNT_W+3:0]              cnt_ext;
  logic [IDX_W+3:0]              pick_ext;
  logic                          table_full;
  logic                          cand;
  logic                          lt;
  logic                          gt;
  logic                          take;

  // requested amount taken modulo the table's size width
  assign amt_ext       = {{SIZE_BITS{1'b0}}, in_req.amount};
  assign amt_in        = amt_ext[SIZE_BITS-1:0];
  assign app_size_ext  = {16'b0, amt_in};
  assign pick_size_ext = {16'b0, pick_size_r};
  assign cnt_ext       = {4'b0, count};
  assign pick_ext      = {4'b0, pick_r};
  assign table_full    = (count == CNT_W'(MAX_PARTITIONS));

  assign acc = in_req.valid && in_req.ready;

  // shared compare unit: one table entry per cycle
  assign cand = cmp_vld_r && !rd_used && (rd_size >= amt_r);
  assign lt   = rd_size < pick_size_r;
  assign gt   = pick_size_r < rd_size;
  assign take = cand && (!found_r ||
                         ((fit_policy == fpfa_pkg::POL_BEST)  && lt) ||
                         ((fit_policy == fpfa_pkg::POL_WORST) && gt));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    amt_nxt       = amt_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    pick_size_nxt = pick_size_r;
    stat_nxt      = stat_r;
    ridx_nxt      = ridx_r;
    rsize_nxt     = rsize_r;
    tbl_ctl       = '0;
    in_req.ready  = 1'b0;
    res_vld       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          state_nxt = S_DONE;
          stat_nxt  = fpfa_pkg::ST_OK;
          ridx_nxt  = '0;
          rsize_nxt = '0;
          unique case (in_req.action)
            fpfa_pkg::ACT_APPEND: begin
              if (table_full) begin
                stat_nxt = fpfa_pkg::ST_FULL;
              end else begin
                tbl_ctl.append = 1'b1;
                ridx_nxt       = cnt_ext[3:0];
                rsize_nxt      = app_size_ext[15:0];
              end
            end
            fpfa_pkg::ACT_ALLOC: begin
              amt_nxt   = amt_in;
              scan_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            fpfa_pkg::ACT_RELEASE: begin
              tbl_ctl.release_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // consume the entry read last cycle
        if (take) begin
          found_nxt     = 1'b1;
          pick_nxt      = cmp_idx_r;
          pick_size_nxt = rd_size;
        end
        // issue the next read
        if (scan_r != count) begin
          scan_nxt    = scan_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[IDX_W-1:0];
        end else if (!cmp_vld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_DONE;
        if (found_r) begin
          tbl_ctl.mark = 1'b1;
          stat_nxt     = fpfa_pkg::ST_OK;
          ridx_nxt     = pick_ext[3:0];
          rsize_nxt    = pick_size_ext[15:0];
        end else begin
          stat_nxt  = fpfa_pkg::ST_NOFIT;
          ridx_nxt  = '0;
          rsize_nxt = '0;
        end
      end
      S_DONE: begin
        res_vld = 1'b1;
        if (res_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amt_r       <= amt_nxt;
    scan_r      <= scan_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    pick_r      <= pick_nxt;
    pick_size_r <= pick_size_nxt;
    stat_r      <= stat_nxt;
    ridx_r      <= ridx_nxt;
    rsize_r     <= rsize_nxt;
  end

  assign wr_size    = amt_in;
  assign mark_idx   = pick_r;
  assign rd_idx     = scan_r[IDX_W-1:0];
  assign res_status = stat_r;
  assign res_index  = ridx_r;
  assign res_size   = rsize_r;

  // an accepted request always leaves idle
  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r != S_IDLE))
    else $error("accepted request did not start work");

  // an entry is marked only after a fitting partition was found
  a_mark_found: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_ctl.mark |-> (found_r && (state_r == S_FIN)))
    else $error("mark without a fitting partition");

  // never append past the table end
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_ctl.append |-> !table_full)
    else $error("append into a full table");

  // the scan index never runs beyond the fill count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_r <= count))
    else $error("scan index beyond table fill");

endmodule

`default_nettype wire

### src/fixed_partition_fit_allocator.sv
// Flow: append, release and other requests go from idle straight to the done state,
//   and their result then passes into the result register; an allocate goes from idle
//   through the scan and finish states to done, the scan covering every entry in the table.
// Throughput: one request at a time; the next is taken the cycle after the result is
//   registered, and an allocate's scan is paced by the single compare
//   unit stepping one table entry per cycle through the registered size memory read.
// Reset: synchronous active-low rst_n empties the table, clears all marks, policy first fit.
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator: fixed-partition fit allocator top level
// Holds the fit policy register and the result register, and joins the
// sequencer with the partition table.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_fit_allocator #(
  parameter int unsigned MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
  parameter int unsigned SIZE_BITS      = fpfa_pkg::SIZE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  fpfa_req_if.sink                           in_req,
  fpfa_rsp_if.source                         out_rsp,
  input  wire logic                          cfg_wr_en,
  input  wire logic [fpfa_pkg::POLICY_W-1:0] cfg_wr_data
);

  localparam int unsigned IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PARTITIONS + 1);

  logic [fpfa_pkg::POLICY_W-1:0] fit_policy_r;
  fpfa_pkg::tbl_ctl_t            tbl_ctl;
  logic [SIZE_BITS-1:0]          wr_size;
  logic [IDX_W-1:0]              mark_idx;
  logic [IDX_W-1:0]              rd_idx;
  logic [SIZE_BITS-1:0]          rd_size;
  logic                          rd_used;
  logic [CNT_W-1:0]              count;
  logic                          res_vld;
  logic                          res_rdy;
  logic [fpfa_pkg::STATUS_W-1:0] res_status;
  logic [fpfa_pkg::INDEX_W-1:0]  res_index;
  logic [fpfa_pkg::PSIZE_W-1:0]  res_size;

  logic                          out_vld_r;
  logic [fpfa_pkg::STATUS_W-1:0] out_status_r;
  logic [fpfa_pkg::INDEX_W-1:0]  out_index_r;
  logic [fpfa_pkg::PSIZE_W-1:0]  out_size_r;

  // fit policy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= fpfa_pkg::POL_FIRST;
    end else if (cfg_wr_en) begin
      fit_policy_r <= cfg_wr_data;
    end
  end

  fpfa_seq #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .fit_policy (fit_policy_r),
    .tbl_ctl    (tbl_ctl),
    .wr_size    (wr_size),
    .mark_idx   (mark_idx),
    .rd_idx     (rd_idx),
    .rd_size    (rd_size),
    .rd_used    (rd_used),
    .count      (count),
    .res_vld    (res_vld),
    .res_rdy    (res_rdy),
    .res_status (res_status),
    .res_index  (res_index),
    .res_size   (res_size)
  );

  fpfa_table #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tbl_ctl),
    .wr_size  (wr_size),
    .mark_idx (mark_idx),
    .rd_idx   (rd_idx),
    .rd_size  (rd_size),
    .rd_used  (rd_used),
    .count    (count)
  );

  // result register
  assign res_rdy = !out_vld_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_vld && res_rdy) begin
      out_vld_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_rdy) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_size_r   <= res_size;
    end
  end

  assign out_rsp.valid           = out_vld_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.partition_index = out_index_r;
  assign out_rsp.partition_size  = out_size_r;

endmodule

`default_nettype wire

### verif/fpfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_checker: result checker for the fixed-partition fit allocator
// Watches the request, result and policy ports, keeps its own copy of the
// partition table, predicts one result per accepted request and compares it
// field by field with the results the block hands out, in order.
// ----------------------------------------------------------------------------

module fpfa_checker
  import fpfa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  fpfa_req_if                 req_ch,
  fpfa_rsp_if                 rsp_ch,
  input  logic                cfg_wr_en,
  input  logic [POLICY_W-1:0] cfg_wr_data,
  output int unsigned         mismatches,
  output int unsigned         outstanding,
  output int unsigned         n_checked,
  output int unsigned         n_ok,
  output int unsigned         n_nofit,
  output int unsigned         n_full
);

  localparam int unsigned TABLE_DEPTH = MAX_PARTITIONS_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    logic [PSIZE_W-1:0]  size;
  } alloc_result_t;

  // shadow partition table and policy
  logic [AMOUNT_W-1:0] shadow_sizes [TABLE_DEPTH];
  logic                shadow_used  [TABLE_DEPTH];
  int unsigned         shadow_fill;
  logic [POLICY_W-1:0] shadow_policy;

  alloc_result_t expected_results[$];
  int unsigned   err_cnt, result_cnt, ok_cnt, nofit_cnt, full_cnt;

  // work out the result of one request and update the shadow table
  function automatic alloc_result_t predict_outcome(input logic [ACTION_W-1:0] act,
                                                    input logic [AMOUNT_W-1:0] amt);
    alloc_result_t r;
    bit            found;
    int unsigned   pick;
    r     = '0;
    found = 1'b0;
    pick  = 0;
    case (act)
      ACT_APPEND: begin
        if (shadow_fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_sizes[shadow_fill] = amt;
          shadow_used[shadow_fill]  = 1'b0;
          r.status = ST_OK;
          r.index  = INDEX_W'(shadow_fill);
          r.size   = PSIZE_W'(amt);
          shadow_fill++;
        end
      end
      ACT_ALLOC: begin
        // scan free adequate entries; ties keep the lowest index
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_used[i] || shadow_sizes[i] < amt) continue;
          if (!found) begin
            found = 1'b1;
            pick  = i;
            if (shadow_policy != POL_BEST && shadow_policy != POL_WORST) break;
          end else if (shadow_policy == POL_BEST && shadow_sizes[i] < shadow_sizes[pick]) begin
            pick = i;
          end else if (shadow_policy == POL_WORST && shadow_sizes[i] > shadow_sizes[pick]) begin
            pick = i;
          end
        end
        if (!found) begin
          r.status = ST_NOFIT;
        end else begin
          shadow_used[pick] = 1'b1;
          r.status = ST_OK;
          r.index  = INDEX_W'(pick);
          r.size   = PSIZE_W'(shadow_sizes[pick]);
        end
      end
      ACT_RELEASE: begin
        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
        r.status = ST_OK;
      end
      default: begin
        r.status = ST_OK;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] result %0d mismatch: %s", $time, result_cnt, msg);
  endtask

  // sample both channels and the policy port at each rising edge
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      shadow_fill   = 0;
      shadow_policy = POL_FIRST;
      err_cnt    = 0;
      result_cnt = 0;
      ok_cnt     = 0;
      nofit_cnt  = 0;
      full_cnt   = 0;
    end else begin
      if (cfg_wr_en) shadow_policy = cfg_wr_data;

      // compare an accepted result with the oldest expectation
      if (rsp_ch.valid && rsp_ch.ready) begin
        result_cnt++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d index %0d size %0d",
                                    rsp_ch.status, rsp_ch.partition_index,
                                    rsp_ch.partition_size));
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_ch.status, want.status));
          if (rsp_ch.partition_index !== want.index)
            report_mismatch($sformatf("partition_index %0d, expected %0d",
                                      rsp_ch.partition_index, want.index));
          if (rsp_ch.partition_size !== want.size)
            report_mismatch($sformatf("partition_size %0d, expected %0d",
                                      rsp_ch.partition_size, want.size));
          case (want.status)
            ST_NOFIT: nofit_cnt++;
            ST_FULL:  full_cnt++;
            default:  ok_cnt++;
          endcase
        end
      end

      // predict the result of an accepted request
      if (req_ch.valid && req_ch.ready)
        expected_results.push_back(predict_outcome(req_ch.action, req_ch.amount));
    end
    outstanding <= expected_results.size();
    mismatches  <= err_cnt;
    n_checked   <= result_cnt;
    n_ok        <= ok_cnt;
    n_nofit     <= nofit_cnt;
    n_full      <= full_cnt;
  end

endmodule

### verif/tb_fixed_partition_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_partition_fit_allocator: testbench top for the fit allocator
// Drives a directed pass over table fill, table full, no fit, release and
// every fit policy, then random allocate/release runs under each policy
// with bursty requests, a stalling result side and one long output stall.
// ----------------------------------------------------------------------------

module tb_fixed_partition_fit_allocator;
  import fpfa_pkg::*;

  // codes with no name of their own in the package
  localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;
  localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

  localparam int unsigned PHASE_ITEMS  = 250;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned DRAIN_LIMIT  = 5000;
  localparam int unsigned HOLD_START   = 3000;
  localparam int unsigned HOLD_CYCLES  = 600;

  typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_mode_e;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [POLICY_W-1:0] cfg_wr_data;

  int unsigned mismatches, outstanding, n_checked, n_ok, n_nofit, n_full;
  int unsigned burst_left, n_sent, n_directed;
  logic [AMOUNT_W-1:0] known_sizes[$];
  logic [POLICY_W-1:0] phase_policy [4] = '{POL_BEST, POL_WORST, POL_UNUSED, POL_FIRST};

  fpfa_req_if req_ch ();
  fpfa_rsp_if rsp_ch ();

  fixed_partition_fit_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch),
    .out_rsp     (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  fpfa_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ch      (req_ch),
    .rsp_ch      (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .n_checked   (n_checked),
    .n_ok        (n_ok),
    .n_nofit     (n_nofit),
    .n_full      (n_full)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // offer one request and hold it until taken; bursts with random gaps
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [AMOUNT_W-1:0] amt);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.amount <= amt;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
    n_sent++;
    if (act == ACT_APPEND && known_sizes.size() < MAX_PARTITIONS_DEF) known_sizes.push_back(amt);
  endtask

  // stop offering, wait for every result, then let the block settle
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(input logic [POLICY_W-1:0] pol);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pol;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // requested size: mostly near a size held in the table
  function automatic logic [AMOUNT_W-1:0] pick_alloc_amount();
    logic [AMOUNT_W-1:0] base;
    int unsigned         roll;
    roll = $urandom_range(0, 99);
    base = (known_sizes.size() != 0) ? known_sizes[$urandom_range(0, known_sizes.size() - 1)]
                                     : '0;
    if (roll < 40) return base;
    if (roll < 60) return (base == '1) ? base : base + 1'b1;
    if (roll < 75) return '0;
    return AMOUNT_W'($urandom);
  endfunction

  // result side: changing stall patterns plus one long hold-off
  initial begin
    int unsigned cyc, hold, mode_left;
    rx_mode_e    mode;
    rsp_ch.ready = 1'b0;
    cyc       = 0;
    hold      = 0;
    mode_left = 0;
    mode      = RX_ALWAYS;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == HOLD_START) hold = HOLD_CYCLES;
      if (hold != 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS:       rsp_ch.ready <= 1'b1;
          RX_COIN:         rsp_ch.ready <= 1'($urandom_range(0, 1));
          RX_EVERY_FOURTH: rsp_ch.ready <= (cyc % 4 == 0);
          default:         rsp_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned run, phase_items;
    req_ch.valid  = 1'b0;
    req_ch.action = ACT_APPEND;
    req_ch.amount = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = POL_FIRST;
    rst_n         = 1'b0;
    burst_left    = 0;
    n_sent        = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, unused action, extreme sizes, first fit
    send_request(ACT_ALLOC, 16'd0);
    send_request(ACT_RELEASE, 16'hFFFF);
    send_request(ACT_NOP, 16'hFFFF);
    send_request(ACT_APPEND, 16'd0);
    send_request(ACT_APPEND, 16'hFFFF);
    send_request(ACT_APPEND, 16'd100);
    send_request(ACT_APPEND, 16'd50);
    send_request(ACT_APPEND, 16'd100);
    send_request(ACT_ALLOC, 16'd0);
    send_request(ACT_ALLOC, 16'hFFFF);
    send_request(ACT_ALLOC, 16'hFFFF);
    send_request(ACT_ALLOC, 16'd60);
    send_request(ACT_RELEASE, 16'd0);

    // best fit with a tie on size
    wait_idle();
    write_policy(POL_BEST);
    send_request(ACT_ALLOC, 16'd60);
    send_request(ACT_ALLOC, 16'd60);
    send_request(ACT_ALLOC, 16'd60);

    // worst fit
    wait_idle();
    write_policy(POL_WORST);
    send_request(ACT_RELEASE, 16'd0);
    send_request(ACT_ALLOC, 16'd0);

    // unused policy code, then fill the table and overflow it
    wait_idle();
    write_policy(POL_UNUSED);
    send_request(ACT_ALLOC, 16'd0);
    for (int k = 0; k < 11; k++) begin
      if (k % 3 == 0) send_request(ACT_APPEND, 16'd100);
      else if (k % 3 == 1) send_request(ACT_APPEND, AMOUNT_W'($urandom_range(1, 300)));
      else send_request(ACT_APPEND, AMOUNT_W'($urandom));
    end
    send_request(ACT_APPEND, 16'h1234);
    n_directed = n_sent;

    // random allocate runs closed by a release, plus some noise
    foreach (phase_policy[p]) begin
      wait_idle();
      write_policy(phase_policy[p]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) begin
          run = $urandom_range(1, 18);
          repeat (run) send_request(ACT_ALLOC, pick_alloc_amount());
          send_request(ACT_RELEASE, AMOUNT_W'($urandom));
          phase_items += run + 1;
        end else begin
          send_request(ACTION_W'($urandom_range(0, 3)), AMOUNT_W'($urandom));
          phase_items++;
        end
      end
    end

    wait_idle();
    $display("Sent %0d requests (%0d directed) under all four fit policy codes, with a long result stall.",
             n_sent, n_directed);
    $display("Checked %0d results: %0d success, %0d no fit, %0d table full.",
             n_checked, n_ok, n_nofit, n_full);
    if (outstanding != 0) $display("results still missing: %0d", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("Verification failed");
    $finish;
  end

endmodule
